// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the ray/segment hit RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CHK_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, off while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

// ===== hw/rtl/rsh_pkg.sv =====
// Types, constants and the CORDIC angle table for the ray/segment hit core.
// No dependencies; the core, front, queue and back RTL files use it by scoped names.
`timescale 1ns / 1ps

package rsh_pkg;

   // Coordinates are Q16.16; the scale cancels in every formula.
   localparam int ANGLE_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CORDIC_STEPS    = 30;
   localparam int DIV_STEPS       = 41;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] DIR_ONE     = 34'sd1073741824;
   localparam logic [40:0]        T_CAP       = 41'h100_0000_0000;
   localparam logic [30:0]        DIST_MAX    = 31'h7FFF_FFFF;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [15:0]        heading;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } rsh_req_type;

   typedef struct packed {
      logic               hit;
      logic [30:0]        distance;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } rsh_rsp_type;

   // One classified item handed from the front to the back.
   typedef struct packed {
      logic               hit;
      logic [66:0]        t_num;
      logic [65:0]        t_den;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
   } rsh_job_type;

   // atan(2^-i) as a fraction of a 2^32 full turn.
   function automatic logic [31:0] atan_turn(input int idx);
      unique case (idx)
         0:  return 32'h2000_0000;
         1:  return 32'h12E4_051E;
         2:  return 32'h09FB_385B;
         3:  return 32'h0511_11D4;
         4:  return 32'h028B_0D43;
         5:  return 32'h0145_D7E1;
         6:  return 32'h00A2_F61E;
         7:  return 32'h0051_7C55;
         8:  return 32'h0028_BE53;
         9:  return 32'h0014_5F2F;
         10: return 32'h000A_2F98;
         11: return 32'h0005_17CC;
         12: return 32'h0002_8BE6;
         13: return 32'h0001_45F3;
         14: return 32'h0000_A2FA;
         15: return 32'h0000_517D;
         16: return 32'h0000_28BE;
         17: return 32'h0000_145F;
         18: return 32'h0000_0A30;
         19: return 32'h0000_0518;
         20: return 32'h0000_028C;
         21: return 32'h0000_0146;
         22: return 32'h0000_00A3;
         23: return 32'h0000_0051;
         24: return 32'h0000_0029;
         25: return 32'h0000_0014;
         26: return 32'h0000_000A;
         27: return 32'h0000_0005;
         28: return 32'h0000_0003;
         29: return 32'h0000_0001;
         default: return 32'h0000_0000;
      endcase
   endfunction

endpackage

// ===== hw/rtl/ray_segment_hit_core.sv =====
// rsp_valid pulses once for each beat taken at start; 1 beat per cycle outside reset.
// Depth is set by the 30-stage CORDIC and the 41-stage one-bit-per-stage divider.
// Results are shown for one cycle each; the receiver cannot stall, so busy
// is high only during reset. Reset is synchronous, active high, and clears
// every valid flag and the queue; data registers are not reset.
// Depends on rsh_pkg, rsh_front, rsh_queue, rsh_back.
`timescale 1ns / 1ps

module ray_segment_hit_core #(
   parameter int ANGLE_BITS  = rsh_pkg::ANGLE_BITS_DEF,
   parameter int QUEUE_DEPTH = rsh_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rsh_pkg::rsh_req_type req_item,
   output logic                 rsp_valid,
   output rsh_pkg::rsh_rsp_type rsp_item
);

   // Take a beat whenever start is high outside reset.
   logic                 take_w;
   logic                 fq_valid, qb_valid;
   rsh_pkg::rsh_job_type fq_job, qb_job;

   assign busy   = reset;
   assign take_w = start && !busy;

   // Front: direction by CORDIC, cross products, classify hit or miss.
   rsh_front #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (take_w),
      .in_item  (req_item),
      .out_valid(fq_valid),
      .out_job  (fq_job)
   );

   // Queue: decouples the halves; the back drains one beat per cycle,
   // so it never holds more than one entry here.
   rsh_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fq_valid),
      .in_job   (fq_job),
      .out_valid(qb_valid),
      .out_ready(1'b1),
      .out_job  (qb_job)
   );

   // Back: divide for t, saturate, form the hit point, register the result.
   rsh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (qb_valid),
      .in_job   (qb_job),
      .out_valid(rsp_valid),
      .out_item (rsp_item)
   );

endmodule

// ===== hw/rtl/rsh_front.sv =====
// Front end: CORDIC direction, cross products, determinant and hit classification.
// Depends on rsh_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsh_front #(
   parameter int ANGLE_BITS = rsh_pkg::ANGLE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  rsh_pkg::rsh_req_type in_item,
   output logic                 out_valid,
   output rsh_pkg::rsh_job_type out_job
);

   localparam int NS = rsh_pkg::CORDIC_STEPS;

   typedef struct packed {
      logic [1:0]         quad;
      logic signed [32:0] sx;
      logic signed [32:0] sy;
      logic signed [32:0] qx;
      logic signed [32:0] qy;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
   } side_type;

   function automatic logic signed [31:0] clamp_dir(input logic signed [33:0] v);
      if (v > rsh_pkg::DIR_ONE) return 32'(rsh_pkg::DIR_ONE);
      if (v < -rsh_pkg::DIR_ONE) return 32'(-rsh_pkg::DIR_ONE);
      return 32'(v);
   endfunction

   // Stage 0: quadrant split and segment vectors.
   logic [ANGLE_BITS-1:0] ang_w;
   logic [31:0]           turn_w;
   logic [31:0]           res_w;
   logic [1:0]            quad_w;
   side_type              side_in;

   always_comb begin
      ang_w        = ANGLE_BITS'(in_item.heading);
      turn_w       = {ang_w, {(32-ANGLE_BITS){1'b0}}};
      quad_w       = 2'((turn_w + 32'h2000_0000) >> 30);
      res_w        = turn_w - {quad_w, 30'd0};
      side_in.quad = quad_w;
      side_in.sx   = 33'($signed(in_item.end_x)) - 33'($signed(in_item.start_x));
      side_in.sy   = 33'($signed(in_item.end_y)) - 33'($signed(in_item.start_y));
      side_in.qx   = 33'($signed(in_item.start_x)) - 33'($signed(in_item.origin_x));
      side_in.qy   = 33'($signed(in_item.start_y)) - 33'($signed(in_item.origin_y));
      side_in.ox   = in_item.origin_x;
      side_in.oy   = in_item.origin_y;
   end

   logic [NS:0]        cv_ff;
   logic signed [33:0] cx_ff [NS+1];
   logic signed [33:0] cy_ff [NS+1];
   logic signed [33:0] cz_ff [NS+1];
   side_type           cs_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else begin
         cv_ff <= {cv_ff[NS-1:0], in_valid};
      end
      cx_ff[0] <= rsh_pkg::CORDIC_GAIN;
      cy_ff[0] <= '0;
      cz_ff[0] <= 34'($signed(res_w));
      cs_ff[0] <= side_in;
   end

   // One micro-rotation per stage.
   for (genvar gi = 0; gi < NS; gi++) begin : g_rot
      always_ff @(posedge clock) begin
         if (cz_ff[gi] >= 0) begin
            cx_ff[gi+1] <= cx_ff[gi] - (cy_ff[gi] >>> gi);
            cy_ff[gi+1] <= cy_ff[gi] + (cx_ff[gi] >>> gi);
            cz_ff[gi+1] <= cz_ff[gi] - $signed({2'b00, rsh_pkg::atan_turn(gi)});
         end else begin
            cx_ff[gi+1] <= cx_ff[gi] + (cy_ff[gi] >>> gi);
            cy_ff[gi+1] <= cy_ff[gi] - (cx_ff[gi] >>> gi);
            cz_ff[gi+1] <= cz_ff[gi] + $signed({2'b00, rsh_pkg::atan_turn(gi)});
         end
         cs_ff[gi+1] <= cs_ff[gi];
      end
   end

   // Clamp and rotate back into the quadrant.
   logic signed [31:0] rx_w, ry_w, dx_in, dy_in;

   always_comb begin
      rx_w = clamp_dir(cx_ff[NS]);
      ry_w = clamp_dir(cy_ff[NS]);
      unique case (cs_ff[NS].quad)
         2'd0: begin dx_in = rx_w;  dy_in = ry_w;  end
         2'd1: begin dx_in = -ry_w; dy_in = rx_w;  end
         2'd2: begin dx_in = -rx_w; dy_in = -ry_w; end
         2'd3: begin dx_in = ry_w;  dy_in = -rx_w; end
      endcase
   end

   logic               rv_ff, mv_ff, dv_ff, ov_ff;
   logic signed [31:0] rdx_ff, rdy_ff, mdx_ff, mdy_ff, ddx_ff, ddy_ff;
   side_type           rs_ff, ms_ff, ds_ff;
   logic signed [65:0] p_dsy_ff, p_dysx_ff, p_qxdy_ff, p_qydx_ff, p_qxsy_ff, p_qysx_ff;
   logic signed [65:0] det_ff, sn_ff;
   logic signed [66:0] tn_ff;
   rsh_pkg::rsh_job_type job_ff;
   rsh_pkg::rsh_job_type job_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         mv_ff <= 1'b0;
         dv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         rv_ff <= cv_ff[NS];
         mv_ff <= rv_ff;
         dv_ff <= mv_ff;
         ov_ff <= dv_ff;
      end
      rdx_ff <= dx_in;
      rdy_ff <= dy_in;
      rs_ff  <= cs_ff[NS];
      // Products.
      p_dsy_ff  <= 66'(rdx_ff) * 66'($signed(rs_ff.sy));
      p_dysx_ff <= 66'(rdy_ff) * 66'($signed(rs_ff.sx));
      p_qxdy_ff <= 66'($signed(rs_ff.qx)) * 66'(rdy_ff);
      p_qydx_ff <= 66'($signed(rs_ff.qy)) * 66'(rdx_ff);
      p_qxsy_ff <= 66'($signed(rs_ff.qx)) * 66'($signed(rs_ff.sy));
      p_qysx_ff <= 66'($signed(rs_ff.qy)) * 66'($signed(rs_ff.sx));
      mdx_ff    <= rdx_ff;
      mdy_ff    <= rdy_ff;
      ms_ff     <= rs_ff;
      // Differences.
      det_ff <= p_dsy_ff - p_dysx_ff;
      sn_ff  <= p_qxdy_ff - p_qydx_ff;
      tn_ff  <= 67'(p_qxsy_ff) - 67'(p_qysx_ff);
      ddx_ff <= mdx_ff;
      ddy_ff <= mdy_ff;
      ds_ff  <= ms_ff;
      job_ff <= job_in;
   end

   // Classify: sign of s and t, and range of s, against the determinant.
   logic        dneg_w, sneg_w, tneg_w, s_ok_w, t_ok_w;
   logic [65:0] det_mag_w, sn_mag_w;

   always_comb begin
      dneg_w    = det_ff[65];
      sneg_w    = sn_ff[65];
      tneg_w    = tn_ff[66];
      det_mag_w = dneg_w ? 66'(-det_ff) : 66'(det_ff);
      sn_mag_w  = sneg_w ? 66'(-sn_ff) : 66'(sn_ff);
      s_ok_w    = ((sn_ff == '0) || (sneg_w == dneg_w)) && (sn_mag_w <= det_mag_w);
      t_ok_w    = (tn_ff == '0) || (tneg_w == dneg_w);
      job_in.hit      = (det_ff != '0) && s_ok_w && t_ok_w;
      job_in.t_num    = tneg_w ? 67'(-tn_ff) : 67'(tn_ff);
      job_in.t_den    = det_mag_w;
      job_in.dir_x    = ddx_ff;
      job_in.dir_y    = ddy_ff;
      job_in.origin_x = ds_ff.ox;
      job_in.origin_y = ds_ff.oy;
   end

   assign out_valid = ov_ff;
   assign out_job   = job_ff;

   `CHK_IMPLIES(f_hit_has_den, clock, reset, out_valid && out_job.hit, out_job.t_den != '0)

endmodule

// ===== hw/rtl/rsh_queue.sv =====
// Short queue between the front and back halves of the hit core.
// Depends on rsh_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsh_queue #(
   parameter int DEPTH = rsh_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  rsh_pkg::rsh_job_type in_job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rsh_pkg::rsh_job_type out_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsh_pkg::rsh_job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 push_w, pop_w;

   assign out_valid = (count_ff != '0);
   assign pop_w     = out_valid && out_ready;
   assign push_w    = in_valid;
   assign out_job   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_w) begin
         mem_ff[wr_ptr_ff] <= in_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_w) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_w) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_w && !pop_w) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_w && !push_w) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `CHK_IMPLIES(q_no_overflow, clock, reset, push_w, !((count_ff == CNT_W'(DEPTH)) && !pop_w))
   `CHK_NEXT(q_push_lands, clock, reset, push_w, count_ff != '0)

endmodule

// ===== hw/rtl/rsh_back.sv =====
// Back end: distance divider, saturation and hit point for the hit core.
// Depends on rsh_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsh_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  rsh_pkg::rsh_job_type in_job,
   output logic                 out_valid,
   output rsh_pkg::rsh_rsp_type out_item
);

   localparam int DS = rsh_pkg::DIV_STEPS;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
   } carry_type;

   // Divider pipeline: one quotient bit per stage.
   logic [DS:0]  vv_ff;
   logic [65:0]  rem_ff [DS+1];
   logic [65:0]  den_ff [DS+1];
   logic [DS-1:0] nb_ff [DS+1];
   logic [DS-1:0] quo_ff [DS+1];
   logic          ovf_ff [DS+1];
   carry_type     cr_ff  [DS+1];
   carry_type     carry_in;

   always_comb begin
      carry_in.hit      = in_job.hit;
      carry_in.dir_x    = in_job.dir_x;
      carry_in.dir_y    = in_job.dir_y;
      carry_in.origin_x = in_job.origin_x;
      carry_in.origin_y = in_job.origin_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vv_ff <= '0;
      end else begin
         vv_ff <= {vv_ff[DS-1:0], in_valid};
      end
      // A quotient of 2^41 or more saturates anyway.
      ovf_ff[0] <= {10'd0, in_job.t_num} >= {in_job.t_den, 11'd0};
      rem_ff[0] <= 66'(in_job.t_num >> 11);
      nb_ff[0]  <= {in_job.t_num[10:0], 30'd0};
      den_ff[0] <= in_job.t_den;
      quo_ff[0] <= '0;
      cr_ff[0]  <= carry_in;
   end

   for (genvar gk = 0; gk < DS; gk++) begin : g_div
      logic [66:0] trial_w;
      assign trial_w = {rem_ff[gk], nb_ff[gk][DS-1]};
      always_ff @(posedge clock) begin
         if (trial_w >= {1'b0, den_ff[gk]}) begin
            rem_ff[gk+1] <= 66'(trial_w - {1'b0, den_ff[gk]});
            quo_ff[gk+1] <= {quo_ff[gk][DS-2:0], 1'b1};
         end else begin
            rem_ff[gk+1] <= trial_w[65:0];
            quo_ff[gk+1] <= {quo_ff[gk][DS-2:0], 1'b0};
         end
         nb_ff[gk+1]  <= nb_ff[gk] << 1;
         den_ff[gk+1] <= den_ff[gk];
         ovf_ff[gk+1] <= ovf_ff[gk];
         cr_ff[gk+1]  <= cr_ff[gk];
      end
   end

   // Saturate t, take direction magnitudes.
   logic [40:0] t_in;
   logic [30:0] dist_in, mx_in, my_in;

   always_comb begin
      t_in    = (ovf_ff[DS] || (quo_ff[DS] > rsh_pkg::T_CAP)) ? rsh_pkg::T_CAP : quo_ff[DS];
      dist_in = (t_in > 41'(rsh_pkg::DIST_MAX)) ? rsh_pkg::DIST_MAX : t_in[30:0];
      mx_in   = cr_ff[DS].dir_x[31] ? 31'(-cr_ff[DS].dir_x) : 31'(cr_ff[DS].dir_x);
      my_in   = cr_ff[DS].dir_y[31] ? 31'(-cr_ff[DS].dir_y) : 31'(cr_ff[DS].dir_y);
   end

   logic               sv_ff, pv_ff, av_ff, fv_ff;
   logic [40:0]        t_ff;
   logic [30:0]        mx_ff, my_ff;
   logic [30:0]        sd_ff, pd_ff, ad_ff;
   carry_type          sc_ff, pc_ff, ac_ff;
   logic [50:0]        phx_ff, phy_ff;
   logic [51:0]        plx_ff, ply_ff;
   logic signed [41:0] offx_ff, offy_ff;
   rsh_pkg::rsh_rsp_type rsp_ff;

   // Offset = ((t * |d|) >> 30) masked to 40 bits, signed by d.
   logic [71:0]        wx_w, wy_w;
   logic signed [41:0] offx_in, offy_in, sumx_w, sumy_w;
   rsh_pkg::rsh_rsp_type rsp_in;

   function automatic logic signed [31:0] clamp32(input logic signed [41:0] v);
      if (v > 42'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -42'sd2147483648) return 32'sh8000_0000;
      return 32'(v);
   endfunction

   always_comb begin
      wx_w    = {phx_ff, 21'd0} + 72'(plx_ff);
      wy_w    = {phy_ff, 21'd0} + 72'(ply_ff);
      offx_in = pc_ff.dir_x[31] ? -$signed(42'(wx_w[69:30])) : $signed(42'(wx_w[69:30]));
      offy_in = pc_ff.dir_y[31] ? -$signed(42'(wy_w[69:30])) : $signed(42'(wy_w[69:30]));
      sumx_w  = 42'(ac_ff.origin_x) + offx_ff;
      sumy_w  = 42'(ac_ff.origin_y) + offy_ff;
      if (ac_ff.hit) begin
         rsp_in.hit      = 1'b1;
         rsp_in.distance = ad_ff;
         rsp_in.point_x  = clamp32(sumx_w);
         rsp_in.point_y  = clamp32(sumy_w);
      end else begin
         rsp_in.hit      = 1'b0;
         rsp_in.distance = rsh_pkg::DIST_MAX;
         rsp_in.point_x  = '0;
         rsp_in.point_y  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
         pv_ff <= 1'b0;
         av_ff <= 1'b0;
         fv_ff <= 1'b0;
      end else begin
         sv_ff <= vv_ff[DS];
         pv_ff <= sv_ff;
         av_ff <= pv_ff;
         fv_ff <= av_ff;
      end
      t_ff   <= t_in;
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      sd_ff  <= dist_in;
      sc_ff  <= cr_ff[DS];
      // Split t into high and low halves to keep each multiplier narrow.
      phx_ff <= 51'(t_ff[40:21]) * 51'(mx_ff);
      plx_ff <= 52'(t_ff[20:0]) * 52'(mx_ff);
      phy_ff <= 51'(t_ff[40:21]) * 51'(my_ff);
      ply_ff <= 52'(t_ff[20:0]) * 52'(my_ff);
      pd_ff  <= sd_ff;
      pc_ff  <= sc_ff;
      offx_ff <= offx_in;
      offy_ff <= offy_in;
      ad_ff   <= pd_ff;
      ac_ff   <= pc_ff;
      rsp_ff  <= rsp_in;
   end

   assign out_valid = fv_ff;
   assign out_item  = rsp_ff;

   `CHK_IMPLIES(b_miss_shape, clock, reset, out_valid && !out_item.hit,
      (out_item.distance == rsh_pkg::DIST_MAX) && (out_item.point_x == '0)
      && (out_item.point_y == '0))

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for ray_segment_hit_core: one ray against one segment per beat.
// Carries its own bit-exact model of the hit math; depends on rsh_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int  LATENCY     = 81;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  RANDOM_ITEMS = 1150;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   rsh_pkg::rsh_req_type req_item;
   logic                 rsp_valid;
   rsh_pkg::rsh_rsp_type rsp_item;

   rsh_pkg::rsh_rsp_type hits_due[$];
   int          mismatches;
   int          beats_sent;
   int          beats_checked;
   int          hits_seen;
   int          cycle_count;

   // atan(2^-i) as a fraction of a 2^32 full turn
   const longint ATAN_STEP[30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

   ray_segment_hit_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Move a ray offset of t along one direction component, keeping only the low
   // 40 bits of the shifted product the way the datapath does.
   function automatic longint ray_offset(logic [127:0] t, longint d);
      logic [127:0] dmag;
      logic [127:0] w;
      longint       m;
      dmag = (d < 0) ? -d : d;
      w = (t * dmag) >> 30;
      m = longint'({24'h0, w[39:0]});
      return (d < 0) ? -m : m;
   endfunction

   function automatic logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Compute the expected hit, distance and hit point for one ray/segment beat.
   function automatic rsh_pkg::rsh_rsp_type predict_hit(rsh_pkg::rsh_req_type r);
      logic [31:0]        ang;
      logic [31:0]        res;
      logic [1:0]         quad;
      longint             cx, cy, z, ddx, ddy, dx, dy;
      longint             ox, oy, sx, sy, qx, qy, det, sn, snm, detm;
      logic signed [127:0] wqx, wqy, wsx, wsy, tn;
      logic [127:0]       tmag, quo, t;
      logic               dneg, tneg, s_ok, t_ok;
      rsh_pkg::rsh_rsp_type o;
      ang  = {r.heading, 16'h0000};
      quad = 2'((ang + 32'h2000_0000) >> 30);
      res  = ang - {quad, 30'h0};
      z    = longint'(signed'(res));
      cx   = longint'(rsh_pkg::CORDIC_GAIN);
      cy   = 0;
      for (int i = 0; i < 30; i++) begin
         ddx = cy >>> i;
         ddy = cx >>> i;
         if (z >= 0) begin
            cx -= ddx; cy += ddy; z -= ATAN_STEP[i];
         end else begin
            cx += ddx; cy -= ddy; z += ATAN_STEP[i];
         end
      end
      if (cx > longint'(rsh_pkg::DIR_ONE)) cx = longint'(rsh_pkg::DIR_ONE);
      if (cx < -longint'(rsh_pkg::DIR_ONE)) cx = -longint'(rsh_pkg::DIR_ONE);
      if (cy > longint'(rsh_pkg::DIR_ONE)) cy = longint'(rsh_pkg::DIR_ONE);
      if (cy < -longint'(rsh_pkg::DIR_ONE)) cy = -longint'(rsh_pkg::DIR_ONE);
      // rotate the CORDIC result into the quadrant the heading rounds to
      case (quad)
         2'd0: begin dx = cx;  dy = cy;  end
         2'd1: begin dx = -cy; dy = cx;  end
         2'd2: begin dx = -cx; dy = -cy; end
         default: begin dx = cy; dy = -cx; end
      endcase
      ox = r.origin_x; oy = r.origin_y;
      sx = longint'(r.end_x) - longint'(r.start_x);
      sy = longint'(r.end_y) - longint'(r.start_y);
      qx = longint'(r.start_x) - ox;
      qy = longint'(r.start_y) - oy;
      det = dx * sy - dy * sx;
      o.hit = 1'b0;
      o.distance = rsh_pkg::DIST_MAX;
      o.point_x = '0;
      o.point_y = '0;
      if (det != 0) begin
         dneg = det < 0;
         sn   = qx * dy - qy * dx;
         snm  = (sn < 0) ? -sn : sn;
         detm = dneg ? -det : det;
         wqx = qx; wqy = qy; wsx = sx; wsy = sy;
         tn   = wqx * wsy - wqy * wsx;
         tneg = tn < 0;
         s_ok = (sn == 0 || (sn < 0) == dneg) && snm <= detm;
         t_ok = (tn == 0) || (tneg == dneg);
         if (s_ok && t_ok) begin
            tmag = tneg ? -tn : tn;
            quo  = (tmag << 30) / 128'(detm);
            t    = (quo > 128'(rsh_pkg::T_CAP)) ? 128'(rsh_pkg::T_CAP) : quo;
            o.hit = 1'b1;
            o.distance = (t > 128'(rsh_pkg::DIST_MAX)) ? rsh_pkg::DIST_MAX : t[30:0];
            o.point_x = sat32(ox + ray_offset(t, dx));
            o.point_y = sat32(oy + ray_offset(t, dy));
         end
      end
      return o;
   endfunction

   // Offer one beat from a falling edge; return at the falling edge after it is taken.
   task automatic send_ray(rsh_pkg::rsh_req_type item);
      start    <= 1'b1;
      req_item <= item;
      // reset moves at falling edges, so busy is settled at every rising edge
      do @(posedge clock); while (busy);
      hits_due.push_back(predict_hit(item));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (hits_due.size() != 0) @(negedge clock);
   endtask

   function automatic rsh_pkg::rsh_req_type make_ray(int ox, int oy, int hd, int ax,
                                                     int ay, int bx, int by);
      rsh_pkg::rsh_req_type r;
      r.origin_x = ox; r.origin_y = oy; r.heading = hd[15:0];
      r.start_x = ax; r.start_y = ay; r.end_x = bx; r.end_y = by;
      return r;
   endfunction

   function automatic int near_coord(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   // Pick a random beat: mostly segments near the origin so hits are common,
   // plus full-range noise, parallel or collapsed segments and far origins.
   function automatic rsh_pkg::rsh_req_type random_ray();
      rsh_pkg::rsh_req_type r;
      int          kind;
      int          span;
      kind = $urandom_range(99);
      span = 1 << $urandom_range(24, 8);
      r.origin_x = near_coord(span); r.origin_y = near_coord(span);
      r.heading  = 16'($urandom);
      r.start_x  = near_coord(span); r.start_y = near_coord(span);
      r.end_x    = near_coord(span); r.end_y   = near_coord(span);
      if (kind < 20) begin
         r = {$urandom, $urandom, 16'($urandom), $urandom, $urandom, $urandom, $urandom};
      end else if (kind < 28) begin
         r.end_x = r.start_x; r.end_y = r.start_y;
      end else if (kind < 36) begin
         // axis-aligned heading with a segment along the same axis
         r.heading = 16'($urandom_range(3)) << 14;
         if (r.heading[14]) r.end_x = r.start_x;
         else r.end_y = r.start_y;
      end else if (kind < 44) begin
         // far origins to drive saturation of the point and the distance
         r.origin_x = $urandom; r.origin_y = $urandom;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsh_pkg::rsh_rsp_type want;
      if (!reset && rsp_valid) begin
         if (hits_due.size() == 0) begin
            $display("%0t: result with none pending: got %p", $time, rsp_item);
            mismatches++;
         end else begin
            want = hits_due.pop_front();
            beats_checked++;
            if (rsp_item.hit) hits_seen++;
            if (rsp_item.hit !== want.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_item.hit);
               mismatches++;
            end
            if (rsp_item.distance !== want.distance) begin
               $display("%0t: distance expected %h actual %h", $time, want.distance,
                        rsp_item.distance);
               mismatches++;
            end
            if (rsp_item.point_x !== want.point_x) begin
               $display("%0t: point_x expected %h actual %h", $time, want.point_x,
                        rsp_item.point_x);
               mismatches++;
            end
            if (rsp_item.point_y !== want.point_y) begin
               $display("%0t: point_y expected %h actual %h", $time, want.point_y,
                        rsp_item.point_y);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results pending", $time, hits_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Headings on each axis and at the quadrant rounding boundaries.
   task automatic test_quadrants();
      int hd[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'h1FFF,
                    16'hFFFF, 16'h6000};
      foreach (hd[k])
         send_ray(make_ray(0, 0, hd[k], 32'sh0005_0000, 32'sh0005_0000,
                           -32'sh0005_0000, -32'sh0005_0000));
      send_ray(make_ray(0, 0, 16'h0000, 32'sh0003_0000, -32'sh0001_0000,
                        32'sh0003_0000, 32'sh0001_0000));
   endtask

   // Parallel, collapsed, endpoint, on-origin and behind-the-ray cases.
   task automatic test_corner_cases();
      send_ray(make_ray(0, 0, 16'h0000, 32'sh0001_0000, 32'sh0001_0000,
                        32'sh0005_0000, 32'sh0001_0000));
      send_ray(make_ray(0, 0, 16'h0000, 32'sh0002_0000, 0, 32'sh0002_0000, 0));
      send_ray(make_ray(0, 0, 16'h0000, 32'sh0002_0000, 0, 32'sh0002_0000,
                        32'sh0004_0000));
      send_ray(make_ray(0, 0, 16'h0000, 32'sh0002_0000, -32'sh0004_0000,
                        32'sh0002_0000, 0));
      send_ray(make_ray(0, 0, 16'h0000, 0, -32'sh0001_0000, 0, 32'sh0001_0000));
      send_ray(make_ray(0, 0, 16'h0000, -32'sh0002_0000, -32'sh0001_0000,
                        -32'sh0002_0000, 32'sh0001_0000));
      send_ray(make_ray(0, 0, 16'h0000, 32'sh0002_0000, 32'sh0000_0001,
                        32'sh0002_0000, 32'sh0004_0000));
   endtask

   // Extreme coordinates: saturated distance and point, full-scale fields.
   task automatic test_extremes();
      send_ray(make_ray(32'sh8000_0000, 0, 16'h0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_ray(make_ray(32'sh7FFF_0000, 32'sh7FFF_0000, 16'h2000, 32'sh7FFF_FFFF,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
      send_ray(make_ray(32'sh8000_0000, 32'sh8000_0000, 16'hA000, 32'sh7FFF_FFFF,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
      send_ray(make_ray(0, 0, 16'h0001, 32'sh7FFF_FFFF, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_ray(make_ray(-1, -1, 16'hFFFF, -1, -1, -1, -1));
      send_ray(make_ray(0, 0, 16'h0000, 0, 0, 0, 0));
   endtask

   // Random beats in bursts with random gaps; pause once for a full drain.
   task automatic test_random_stream();
      int left;
      int burst;
      bit drained;
      left = RANDOM_ITEMS;
      drained = 1'b0;
      while (left > 0) begin
         burst = $urandom_range(40, 1);
         for (int k = 0; k < burst && left > 0; k++) begin
            send_ray(random_ray());
            left--;
         end
         if (!drained && left <= RANDOM_ITEMS / 2) begin
            drained = 1'b1;
            drain_results();
         end
         else if ($urandom_range(3) != 0) hold_off($urandom_range(12, 1));
      end
   endtask

   initial begin
      mismatches = 0; beats_sent = 0; beats_checked = 0; hits_seen = 0;
      cycle_count = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_quadrants();
      test_corner_cases();
      test_extremes();
      drain_results();
      test_random_stream();
      drain_results();
      repeat (LATENCY + 20) @(negedge clock);
      $display("Sent %0d ray/segment beats, checked %0d results, %0d of them hits.",
               beats_sent, beats_checked, hits_seen);
      $display("Covered all quadrants, parallel and collapsed segments, endpoints, saturation.");
      if (mismatches == 0 && hits_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
